// File: rtl/tcfe_pkg.sv
// shared types, constants and tables for the tilt complementary filter
package tcfe_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam int CordW = 34;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GYRO,
    ST_CORD_INIT,
    ST_CORD_RUN,
    ST_BLEND,
    ST_CHECK,
    ST_HOME,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       gyro;
    logic       cord_init;
    logic       cord_step;
    logic       blend;
    logic       check;
    logic       home;
    logic       out_load;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic mag_ok;
    logic last;
    logic home_set;
  } sts_t;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvShort = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  localparam logic [1:0] ModeXy = 2'd1;
  localparam logic [1:0] ModeZ  = 2'd2;

  localparam logic [2:0] RegGyroScale = 3'd0;
  localparam logic [2:0] RegAxisMode  = 3'd1;
  localparam logic [2:0] RegMagLow    = 3'd2;
  localparam logic [2:0] RegMagHigh   = 3'd3;
  localparam logic [2:0] RegCalib     = 3'd4;
  localparam logic [2:0] RegRearm     = 3'd5;
  localparam logic [2:0] RegShort     = 3'd6;
  localparam logic [2:0] RegLong      = 3'd7;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967;
      5'd2: r = 32'sd919879;   5'd3: r = 32'sd466945;
      5'd4: r = 32'sd234379;   5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;    5'd7: r = 32'sd29335;
      5'd8: r = 32'sd14668;    5'd9: r = 32'sd7334;
      5'd10: r = 32'sd3667;    5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;     5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;     5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;       5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;       default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [16:0] trunc_deg(input logic signed [31:0] a);
    logic signed [32:0] m;
    logic signed [16:0] r;
    m = (a < 0) ? -{a[31], a} : {a[31], a};
    r = m[32:16];
    return (a < 0) ? -r : r;
  endfunction

endpackage

// File: rtl/tcfe_ctrl.sv
// sequencer per sample: gyro, 3 cordic+blend if mag ok, event check, home, output
module tcfe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  tcfe_pkg::sts_t     sts_i,
  output tcfe_pkg::cmd_t     cmd_o
);

  tcfe_pkg::state_e state_q, state_d;
  logic [tcfe_pkg::StepW-1:0] step_q, step_d;
  logic [1:0] axis_q, axis_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcfe_pkg::ST_IDLE;
      step_q      <= '0;
      axis_q      <= tcfe_pkg::AxisX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    in_stall_o  = (state_q != tcfe_pkg::ST_IDLE);
    unique case (state_q)
      tcfe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tcfe_pkg::ST_GYRO;
        end
      end
      tcfe_pkg::ST_GYRO: begin
        cmd_o.gyro = 1'b1;
        axis_d     = tcfe_pkg::AxisX;
        state_d    = tcfe_pkg::ST_CORD_INIT;
      end
      tcfe_pkg::ST_CORD_INIT: begin
        if (sts_i.mag_ok) begin
          cmd_o.cord_init = 1'b1;
          step_d          = '0;
          state_d         = tcfe_pkg::ST_CORD_RUN;
        end else begin
          state_d = tcfe_pkg::ST_CHECK;
        end
      end
      tcfe_pkg::ST_CORD_RUN: begin
        cmd_o.cord_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == tcfe_pkg::StepW'(tcfe_pkg::CordicSteps - 1)) begin
          state_d = tcfe_pkg::ST_BLEND;
        end
      end
      tcfe_pkg::ST_BLEND: begin
        cmd_o.blend = 1'b1;
        if (axis_q == tcfe_pkg::AxisZ) begin
          state_d = tcfe_pkg::ST_CHECK;
        end else begin
          axis_d          = axis_q + 1'b1;
          cmd_o.cord_init = 1'b0;
          state_d         = tcfe_pkg::ST_CORD_INIT;
        end
      end
      tcfe_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = tcfe_pkg::ST_HOME;
      end
      tcfe_pkg::ST_HOME: begin
        cmd_o.home = 1'b1;
        state_d    = tcfe_pkg::ST_OUT;
      end
      tcfe_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tcfe_pkg::ST_IDLE;
        end
      end
      default: state_d = tcfe_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  property p_step_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      state_q == tcfe_pkg::ST_CORD_RUN |-> step_q < tcfe_pkg::StepW'(tcfe_pkg::CordicSteps);
  endproperty
  a_step_bound: assert property (p_step_bound) else $error("cordic step overrun");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q) else $error("result dropped");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == tcfe_pkg::ST_IDLE) else $error("load outside idle");

endmodule

// File: rtl/tcfe_dp.sv
// datapath: angle registers, shared cordic, blend, event and home logic, output register
module tcfe_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcfe_pkg::cmd_t      cmd_i,
  output tcfe_pkg::sts_t      sts_o,
  input  logic signed [15:0]  rate_x_i,
  input  logic signed [15:0]  rate_y_i,
  input  logic signed [15:0]  rate_z_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_y_i,
  input  logic signed [15:0]  accel_z_i,
  input  logic                batch_end_i,
  input  logic                long_blink_busy_i,
  input  logic [23:0]         gyro_scale_i,
  input  logic [1:0]          axis_mode_i,
  input  logic [16:0]         acc_mag_low_i,
  input  logic [16:0]         acc_mag_high_i,
  input  logic [3:0]          calib_batches_i,
  input  logic [8:0]          rearm_limit_i,
  input  logic [8:0]          short_limit_i,
  input  logic [8:0]          long_limit_i,
  output logic signed [31:0]  tilt_x_o,
  output logic signed [31:0]  tilt_y_o,
  output logic signed [31:0]  tilt_z_o,
  output logic [1:0]          blink_event_o,
  output logic                home_valid_o
);

  localparam int W = tcfe_pkg::CordW;

  logic signed [15:0] rx_q, ry_q, rz_q, ax_q, ay_q, az_q;
  logic last_q, busy_q, mag_ok_q;
  logic signed [31:0] ang_q [3];
  logic signed [31:0] ang_d [3];
  logic signed [15:0] home_q [3];
  logic home_set_q, latched_q;
  logic [3:0] bcnt_q;
  logic [1:0] ev_q;
  logic signed [W-1:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [4:0] ci_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  logic [1:0] tev_q;
  logic thv_q;

  logic [17:0] mag;
  assign mag = 18'(ax_q < 0 ? -17'(ax_q) : 17'(ax_q))
             + 18'(ay_q < 0 ? -17'(ay_q) : 17'(ay_q))
             + 18'(az_q < 0 ? -17'(az_q) : 17'(az_q));

  // gyro term
  logic signed [47:0] gacc [3];
  logic signed [15:0] rsel [3];
  always_comb begin
    rsel[0] = rx_q; rsel[1] = ry_q; rsel[2] = rz_q;
    for (int k = 0; k < 3; k++) begin
      logic signed [40:0] p;
      p = 41'(rsel[k]) * $signed({1'b0, gyro_scale_i});
      if (k == 1) p = -p;
      gacc[k] = ((48'(ang_q[k]) <<< 8) + 48'(p) + 48'sd128) >>> 8;
    end
  end

  // cordic operands
  logic signed [15:0] opy, opx;
  always_comb begin
    unique case (cmd_i.axis)
      tcfe_pkg::AxisX: begin opy = ay_q; opx = az_q; end
      tcfe_pkg::AxisY: begin opy = ax_q; opx = az_q; end
      default:         begin opy = ax_q; opx = ay_q; end
    endcase
  end

  logic signed [W-1:0] shx, shy;
  assign shx = cx_q >>> ci_q;
  assign shy = cy_q >>> ci_q;

  // x and y stay zero through the iterations only when both operands were zero
  logic signed [31:0] tilt;
  assign tilt = (cx_q == 0 && cy_q == 0) ? 32'sd0 : cz_q;

  logic signed [31:0] cur_ang;
  assign cur_ang = ang_q[cmd_i.axis];
  logic signed [47:0] bl;
  assign bl = (48'(cur_ang) * 48'sd64225 + 48'(tilt) * 48'sd1311 + 48'sd32768) >>> 16;

  // event check
  logic [16:0] dif [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [16:0] t, h;
      logic [16:0] at, ah;
      t  = tcfe_pkg::trunc_deg(ang_q[k]);
      h  = 17'(home_q[k]);
      at = t < 0 ? 17'(-t) : 17'(t);
      ah = h < 0 ? 17'(-h) : 17'(h);
      dif[k] = at >= ah ? at - ah : ah - at;
    end
  end

  logic [1:0] ev_n;
  logic latch_n;
  always_comb begin
    logic [16:0] dx, dy;
    logic rearm, shx_e, lgx;
    ev_n    = tcfe_pkg::EvNone;
    latch_n = latched_q;
    dx = (axis_mode_i == tcfe_pkg::ModeZ) ? dif[2] : dif[0];
    dy = dif[1];
    rearm = dx < 17'(rearm_limit_i);
    shx_e = dx > 17'(short_limit_i) && dx < 17'(long_limit_i) && !latched_q;
    lgx   = dx > 17'(long_limit_i) && !latched_q;
    if (last_q && home_set_q &&
        (axis_mode_i == tcfe_pkg::ModeXy || axis_mode_i == tcfe_pkg::ModeZ)) begin
      priority if (rearm) begin
        latch_n = 1'b0;
      end else if (shx_e) begin
        ev_n = tcfe_pkg::EvShort;
      end else if (lgx) begin
        latch_n = 1'b1;
        ev_n = (axis_mode_i == tcfe_pkg::ModeXy && busy_q) ? tcfe_pkg::EvNone
                                                           : tcfe_pkg::EvLong;
      end else if (axis_mode_i == tcfe_pkg::ModeXy && !latched_q &&
                   dy > 17'(short_limit_i) && dy < 17'(long_limit_i)) begin
        ev_n = tcfe_pkg::EvShort;
      end else if (axis_mode_i == tcfe_pkg::ModeXy && !latched_q &&
                   dy > 17'(long_limit_i)) begin
        latch_n = 1'b1;
        ev_n = busy_q ? tcfe_pkg::EvNone : tcfe_pkg::EvLong;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rx_q <= rate_x_i; ry_q <= rate_y_i; rz_q <= rate_z_i;
      ax_q <= accel_x_i; ay_q <= accel_y_i; az_q <= accel_z_i;
      last_q <= batch_end_i; busy_q <= long_blink_busy_i;
    end
    if (cmd_i.gyro) begin
      mag_ok_q <= mag > 18'(acc_mag_low_i) && mag < 18'(acc_mag_high_i);
    end
    if (cmd_i.cord_init) begin
      ci_q <= '0;
      if (opx < 0) begin
        cx_q <= -(W'(opx) <<< 8);
        cy_q <= -(W'(opy) <<< 8);
        cz_q <= (opy >= 0) ? 32'sd11796480 : -32'sd11796480;
      end else begin
        cx_q <= W'(opx) <<< 8;
        cy_q <= W'(opy) <<< 8;
        cz_q <= '0;
      end
      if (opx == 0 && opy == 0) cz_q <= '0;
    end else if (cmd_i.cord_step) begin
      ci_q <= ci_q + 1'b1;
      if (cy_q >= 0) begin
        cx_q <= cx_q + shy; cy_q <= cy_q - shx;
        cz_q <= cz_q + tcfe_pkg::atan_deg(ci_q);
      end else begin
        cx_q <= cx_q - shy; cy_q <= cy_q + shx;
        cz_q <= cz_q - tcfe_pkg::atan_deg(ci_q);
      end
    end
    if (cmd_i.out_load) begin
      tx_q <= ang_q[0]; ty_q <= ang_q[1]; tz_q <= ang_q[2];
      tev_q <= ev_q; thv_q <= home_set_q;
    end
    if (cmd_i.home && last_q && !home_set_q) begin
      for (int k = 0; k < 3; k++) home_q[k] <= 16'(tcfe_pkg::trunc_deg(ang_q[k]));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) ang_d[k] = ang_q[k];
    if (cmd_i.gyro) begin
      for (int k = 0; k < 3; k++) ang_d[k] = tcfe_pkg::sat32(gacc[k]);
    end
    if (cmd_i.blend) ang_d[cmd_i.axis] = tcfe_pkg::sat32(bl);
  end

  logic [3:0] bcnt_n;
  assign bcnt_n = (bcnt_q == 4'd15) ? bcnt_q : bcnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) ang_q[k] <= '0;
      home_set_q <= 1'b0;
      latched_q  <= 1'b1;
      bcnt_q     <= '0;
      ev_q       <= tcfe_pkg::EvNone;
    end else begin
      for (int k = 0; k < 3; k++) ang_q[k] <= ang_d[k];
      if (cmd_i.check) begin
        ev_q      <= ev_n;
        latched_q <= latch_n;
      end
      if (cmd_i.home && last_q) begin
        bcnt_q <= bcnt_n;
        if (bcnt_n >= calib_batches_i) home_set_q <= 1'b1;
      end
    end
  end

  assign sts_o.mag_ok   = mag_ok_q;
  assign sts_o.last     = last_q;
  assign sts_o.home_set = home_set_q;

  assign tilt_x_o      = tx_q;
  assign tilt_y_o      = ty_q;
  assign tilt_z_o      = tz_q;
  assign blink_event_o = tev_q;
  assign home_valid_o  = thv_q;

  a_ev_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && !last_q |=> ev_q == tcfe_pkg::EvNone) else $error("event off batch end");

  a_home_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    home_set_q |=> home_set_q) else $error("home lost");

  a_long_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && ev_n == tcfe_pkg::EvLong |=> latched_q) else $error("long without latch");

endmodule

// File: rtl/tilt_complementary_filter_events_unit.sv
// top level of the tilt complementary filter with blink events
// A sample runs the gyro update, three cordic passes with blend when the acceleration
// magnitude is in range (none otherwise), then the event check, home and output steps; its
// length is set by one shared cordic unit that evaluates the three atan2 tilts one after
// another, a step per cycle. One sample is in work at a time; the result word sits in an
// output register, so a new sample can start while the last result waits. Registers are
// read and written over APB at byte address 4*index.
module tilt_complementary_filter_events_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] rate_x_i,
  input  logic signed [15:0] rate_y_i,
  input  logic signed [15:0] rate_z_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               batch_end_i,
  input  logic               long_blink_busy_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] tilt_x_o,
  output logic signed [31:0] tilt_y_o,
  output logic signed [31:0] tilt_z_o,
  output logic [1:0]         blink_event_o,
  output logic               home_valid_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [23:0] gyro_scale_q;
  logic [1:0]  axis_mode_q;
  logic [16:0] mag_low_q, mag_high_q;
  logic [3:0]  calib_q;
  logic [8:0]  rearm_q, short_q, long_q;
  logic [2:0]  ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale_q <= 24'd5872;
      axis_mode_q  <= 2'd0;
      mag_low_q    <= 17'd8000;
      mag_high_q   <= 17'd29000;
      calib_q      <= 4'd10;
      rearm_q      <= 9'd20;
      short_q      <= 9'd30;
      long_q       <= 9'd90;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        tcfe_pkg::RegGyroScale: gyro_scale_q <= pwdata[23:0];
        tcfe_pkg::RegAxisMode:  axis_mode_q  <= pwdata[1:0];
        tcfe_pkg::RegMagLow:    mag_low_q    <= pwdata[16:0];
        tcfe_pkg::RegMagHigh:   mag_high_q   <= pwdata[16:0];
        tcfe_pkg::RegCalib:     calib_q      <= pwdata[3:0];
        tcfe_pkg::RegRearm:     rearm_q      <= pwdata[8:0];
        tcfe_pkg::RegShort:     short_q      <= pwdata[8:0];
        default:                long_q       <= pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tcfe_pkg::RegGyroScale: prdata = {8'd0, gyro_scale_q};
      tcfe_pkg::RegAxisMode:  prdata = {30'd0, axis_mode_q};
      tcfe_pkg::RegMagLow:    prdata = {15'd0, mag_low_q};
      tcfe_pkg::RegMagHigh:   prdata = {15'd0, mag_high_q};
      tcfe_pkg::RegCalib:     prdata = {28'd0, calib_q};
      tcfe_pkg::RegRearm:     prdata = {23'd0, rearm_q};
      tcfe_pkg::RegShort:     prdata = {23'd0, short_q};
      default:                prdata = {23'd0, long_q};
    endcase
  end

  tcfe_pkg::cmd_t cmd;
  tcfe_pkg::sts_t sts;

  tcfe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  tcfe_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .rate_x_i, .rate_y_i, .rate_z_i, .accel_x_i, .accel_y_i, .accel_z_i,
    .batch_end_i, .long_blink_busy_i,
    .gyro_scale_i(gyro_scale_q), .axis_mode_i(axis_mode_q),
    .acc_mag_low_i(mag_low_q), .acc_mag_high_i(mag_high_q),
    .calib_batches_i(calib_q), .rearm_limit_i(rearm_q),
    .short_limit_i(short_q), .long_limit_i(long_q),
    .tilt_x_o, .tilt_y_o, .tilt_z_o, .blink_event_o, .home_valid_o
  );

endmodule
